// ===== hw/rtl/dkn_pkg.sv =====
// shared types and constants for the descriptor k-nearest-neighbor search
`timescale 1ns / 1ps
package dkn_pkg;

    localparam int ELEM_W    = 8;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 10;
    localparam int DIST_W    = 23;
    localparam int ACC_W     = 25;
    localparam int SQ_W      = 16;
    localparam int K_CFG_W   = 5;
    localparam int LEN_CFG_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [KIND_W-1:0] KIND_REF   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCRIPTOR_LENGTH = 1'd1;

    localparam logic [K_CFG_W-1:0]   K_RESET   = 5'd4;
    localparam logic [LEN_CFG_W-1:0] LEN_RESET = 8'd128;

    localparam logic [DIST_W-1:0] DIST_MAX = 23'h7FFFFF;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic emit_load;
        logic err_load;
    } dkn_cmd_t;

    typedef struct packed {
        logic query_done;
        logic no_result;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
        logic emit_last;
    } dkn_status_t;

endpackage

// ===== hw/rtl/dkn_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module dkn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/dkn_datapath.sv =====
// datapath: reference and query stores, distance pipeline, best list, output register
`timescale 1ns / 1ps
module dkn_datapath import dkn_pkg::*; #(
    parameter int MAX_REFERENCES = 1024,
    parameter int MAX_LENGTH     = 128,
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [ELEM_W-1:0]    s_element_value,
    input  dkn_cmd_t             cmd,
    output dkn_status_t          status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_neighbour_index,
    output logic [DIST_W-1:0]    m_distance_squared,
    output logic                 m_error,
    output logic                 m_last
);

    localparam int RDEPTH = MAX_REFERENCES * MAX_LENGTH;
    localparam int AW  = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int QAW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW  = $clog2(MAX_LENGTH + 1);
    localparam int TW  = $clog2(MAX_REFERENCES + 1);
    localparam int KW  = $clog2(MAX_NEIGHBOURS + 1);
    localparam int NIW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

    // configuration
    logic [K_CFG_W-1:0]   k_cfg_reg;
    logic [LEN_CFG_W-1:0] len_cfg_reg;
    logic [LW-1:0]        len_eff;
    logic [KW-1:0]        k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_cfg_reg   <= K_RESET;
            len_cfg_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_NEIGHBOUR_COUNT:   k_cfg_reg   <= cfg_wr_data[K_CFG_W-1:0];
                REG_DESCRIPTOR_LENGTH: len_cfg_reg <= cfg_wr_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = LW'(1);
        end else if ({1'b0, len_cfg_reg} > 9'(MAX_LENGTH)) begin
            len_eff = LW'(MAX_LENGTH);
        end else begin
            len_eff = LW'(len_cfg_reg);
        end
        if ({2'b00, k_cfg_reg} > 7'(MAX_NEIGHBOURS)) begin
            k_eff = KW'(MAX_NEIGHBOURS);
        end else begin
            k_eff = KW'(k_cfg_reg);
        end
    end

    // loading of references and query
    logic [TW-1:0] total_reg, total_next;
    logic [LW-1:0] lp_reg, lp_next, lp_inc;
    logic [AW-1:0] lbase_reg, lbase_next;
    logic [LW-1:0] qp_reg, qp_next, qp_inc;
    logic          ref_we, q_we;
    logic          is_ref, is_query, is_clear;

    assign is_ref   = cmd.accept && (s_kind == KIND_REF);
    assign is_query = cmd.accept && (s_kind == KIND_QUERY);
    assign is_clear = cmd.accept && (s_kind == KIND_CLEAR);

    always_comb begin
        total_next = total_reg;
        lp_next    = lp_reg;
        lbase_next = lbase_reg;
        qp_next    = qp_reg;
        ref_we     = 1'b0;
        q_we       = 1'b0;
        lp_inc     = (lp_reg < len_eff) ? LW'(lp_reg + LW'(1)) : lp_reg;
        qp_inc     = (qp_reg < len_eff) ? LW'(qp_reg + LW'(1)) : qp_reg;
        if (is_ref && (total_reg < TW'(MAX_REFERENCES))) begin
            ref_we  = lp_reg < len_eff;
            lp_next = lp_inc;
            if (lp_inc >= len_eff) begin
                lp_next    = '0;
                total_next = TW'(total_reg + TW'(1));
                lbase_next = AW'(lbase_reg + AW'(MAX_LENGTH));
            end
        end
        if (is_query) begin
            q_we    = qp_reg < len_eff;
            qp_next = (qp_inc >= len_eff) ? '0 : qp_inc;
        end
        if (is_clear) begin
            total_next = '0;
            lp_next    = '0;
            lbase_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            lp_reg    <= '0;
            lbase_reg <= '0;
            qp_reg    <= '0;
        end else begin
            total_reg <= total_next;
            lp_reg    <= lp_next;
            lbase_reg <= lbase_next;
            qp_reg    <= qp_next;
        end
    end

    assign status.query_done = (s_kind == KIND_QUERY) && (qp_inc >= len_eff);
    assign status.no_result  = (k_eff == '0) || (total_reg == '0);

    // scan counters
    logic          scan_init;
    logic [LW-1:0] sj_reg;
    logic [TW-1:0] sref_reg;
    logic [AW-1:0] sbase_reg;
    logic          s_last_elem, s_last_ref;

    assign scan_init   = is_query && status.query_done;
    assign s_last_elem = LW'(sj_reg + LW'(1)) == len_eff;
    assign s_last_ref  = TW'(sref_reg + TW'(1)) == total_reg;
    assign status.scan_last = s_last_elem && s_last_ref;

    always_ff @(posedge aclk) begin
        if (scan_init) begin
            sj_reg    <= '0;
            sref_reg  <= '0;
            sbase_reg <= '0;
        end else if (cmd.scan_step) begin
            if (s_last_elem) begin
                sj_reg    <= '0;
                sref_reg  <= TW'(sref_reg + TW'(1));
                sbase_reg <= AW'(sbase_reg + AW'(MAX_LENGTH));
            end else begin
                sj_reg <= LW'(sj_reg + LW'(1));
            end
        end
    end

    logic [ELEM_W-1:0] ref_rd, q_rd;

    dkn_ram #(.WIDTH(ELEM_W), .DEPTH(RDEPTH)) u_ref_store (
        .aclk    (aclk),
        .wr_en   (ref_we),
        .wr_addr (AW'(lbase_reg + AW'(lp_reg))),
        .wr_data (s_element_value),
        .rd_addr (AW'(sbase_reg + AW'(sj_reg))),
        .rd_data (ref_rd)
    );

    dkn_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LENGTH)) u_query_buf (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (qp_reg[QAW-1:0]),
        .wr_data (s_element_value),
        .rd_addr (sj_reg[QAW-1:0]),
        .rd_data (q_rd)
    );

    // distance pipeline: read, square, accumulate, insert
    logic              rd_v_reg, rd_last_reg;
    logic [TW-1:0]     rd_idx_reg;
    logic              sq_v_reg, sq_last_reg;
    logic [TW-1:0]     sq_idx_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [ACC_W-1:0]  acc_reg, acc_sum;
    logic              dist_v_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [IDX_W-1:0]  dist_idx_reg;
    logic [ELEM_W-1:0] absd;

    assign absd    = (q_rd > ref_rd) ? ELEM_W'(q_rd - ref_rd) : ELEM_W'(ref_rd - q_rd);
    assign acc_sum = ACC_W'(acc_reg + ACC_W'(sq_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            sq_v_reg   <= 1'b0;
            dist_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= cmd.scan_step;
            sq_v_reg   <= rd_v_reg;
            dist_v_reg <= sq_v_reg && sq_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_last_reg <= s_last_elem;
        rd_idx_reg  <= sref_reg;
        sq_last_reg <= rd_last_reg;
        sq_idx_reg  <= rd_idx_reg;
        sq_reg      <= SQ_W'(absd * absd);
        if (scan_init) begin
            acc_reg <= '0;
        end else if (sq_v_reg) begin
            acc_reg <= sq_last_reg ? '0 : acc_sum;
        end
        if (sq_v_reg && sq_last_reg) begin
            dist_reg     <= (acc_sum > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];
            dist_idx_reg <= IDX_W'(sq_idx_reg);
        end
    end

    assign status.pipe_busy = rd_v_reg || sq_v_reg || dist_v_reg;

    // sorted best list, parallel insertion
    logic [DIST_W-1:0] best_d [MAX_NEIGHBOURS];
    logic [IDX_W-1:0]  best_i [MAX_NEIGHBOURS];
    logic [DIST_W-1:0] best_d_next [MAX_NEIGHBOURS];
    logic [IDX_W-1:0]  best_i_next [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] stay;
    logic [KW-1:0]     filled_reg;
    logic [KW-1:0]     emit_reg;

    for (genvar p = 0; p < MAX_NEIGHBOURS; p++) begin : g_ins
        assign stay[p] = (KW'(p) < filled_reg) && (best_d[p] <= dist_reg);
        if (p == 0) begin : g_head
            assign best_d_next[p] = stay[p] ? best_d[p] : dist_reg;
            assign best_i_next[p] = stay[p] ? best_i[p] : dist_idx_reg;
        end else begin : g_body
            assign best_d_next[p] = stay[p] ? best_d[p] :
                                    stay[p-1] ? dist_reg : best_d[p-1];
            assign best_i_next[p] = stay[p] ? best_i[p] :
                                    stay[p-1] ? dist_idx_reg : best_i[p-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (dist_v_reg) begin
            best_d <= best_d_next;
            best_i <= best_i_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            emit_reg   <= '0;
        end else if (scan_init) begin
            filled_reg <= '0;
            emit_reg   <= '0;
        end else begin
            if (dist_v_reg && (filled_reg < k_eff)) begin
                filled_reg <= KW'(filled_reg + KW'(1));
            end
            if (cmd.emit_load) begin
                emit_reg <= KW'(emit_reg + KW'(1));
            end
        end
    end

    assign status.emit_last = KW'(emit_reg + KW'(1)) == filled_reg;

    // output register
    logic m_valid_reg;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load || cmd.err_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_load) begin
            m_neighbour_index  <= '0;
            m_distance_squared <= '0;
            m_error            <= 1'b1;
            m_last             <= 1'b1;
        end else if (cmd.emit_load) begin
            m_neighbour_index  <= best_i[emit_reg[NIW-1:0]];
            m_distance_squared <= best_d[emit_reg[NIW-1:0]];
            m_error            <= 1'b0;
            m_last             <= status.emit_last;
        end
    end

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (filled_reg != '0))
        else $error("emitting from an empty best list");
    a_dist_follows_sq: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_v_reg |-> $past(sq_v_reg))
        else $error("distance valid without a squared term");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load || cmd.err_load) |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");
    a_no_scan_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> !cmd.accept)
        else $error("request accepted during scan");

endmodule

// ===== hw/rtl/dkn_ctrl.sv =====
// controller state machine: request intake, scan, drain and result emission
`timescale 1ns / 1ps
module dkn_ctrl import dkn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output dkn_cmd_t    cmd,
    input  dkn_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.emit_load = 1'b0;
        cmd.err_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && status.query_done) begin
                    state_next = status.no_result ? ST_ERR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (status.out_free) begin
                    cmd.err_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.query_done) |=> (state_reg == ST_SCAN || state_reg == ST_ERR))
        else $error("completed query did not start a search");
    a_drain_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && status.scan_last) |=> (state_reg == ST_DRAIN))
        else $error("scan end not followed by drain");
    a_emit_needs_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !status.pipe_busy)
        else $error("emitting while distances still in flight");

endmodule

// ===== hw/rtl/descriptor_knn_search.sv =====
// top level of the brute-force k-nearest-neighbor descriptor search
`timescale 1ns / 1ps
// The request that completes a query starts a scan that reads one stored
// reference element per cycle from the single read port of the reference
// memory; when the distance pipeline has drained, the block emits one result
// per cycle while the output register is free, for up to neighbour_count
// results (one error result when nothing can be reported). No request is
// taken during scan and emission; a result waiting in the output register
// does not block the next request.
// The reference store needs no initialization after reset.
module descriptor_knn_search import dkn_pkg::*; #(
    parameter int MAX_REFERENCES = 1024,
    parameter int MAX_LENGTH     = 128,
    parameter int MAX_NEIGHBOURS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [ELEM_W-1:0]    s_element_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_neighbour_index,
    output logic [DIST_W-1:0]    m_distance_squared,
    output logic                 m_error,
    output logic                 m_last
);

    dkn_cmd_t    cmd;
    dkn_status_t status;

    dkn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    dkn_datapath #(
        .MAX_REFERENCES (MAX_REFERENCES),
        .MAX_LENGTH     (MAX_LENGTH),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_kind             (s_kind),
        .s_element_value    (s_element_value),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_neighbour_index  (m_neighbour_index),
        .m_distance_squared (m_distance_squared),
        .m_error            (m_error),
        .m_last             (m_last)
    );

endmodule

// ===== sim/tb_top.sv =====
// testbench for descriptor_knn_search: random reference sets and queries checked against a predictor
`timescale 1ns / 1ps
module tb_top;
    import dkn_pkg::*;

    localparam int NUM_REFS    = 1024;
    localparam int MAX_LEN     = 128;
    localparam int MAX_K       = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] dist_sq;
        logic              err;
        logic              last;
    } neighbour_t;

    class knn_scoreboard;
        byte unsigned ref_mem[NUM_REFS*MAX_LEN];
        byte unsigned query_mem[MAX_LEN];
        int           ref_total;
        int           load_pos;
        int           query_pos;
        int           k_reg;
        int           len_reg;
        neighbour_t   pending[$];
        int           mismatches;

        function new();
            ref_total  = 0;
            load_pos   = 0;
            query_pos  = 0;
            k_reg      = K_RESET;
            len_reg    = LEN_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int val);
            if (idx == REG_NEIGHBOUR_COUNT) k_reg = val & 'h1f;
            else len_reg = val & 'hff;
        endfunction

        function int active_len();
            if (len_reg == 0) return 1;
            if (len_reg > MAX_LEN) return MAX_LEN;
            return len_reg;
        endfunction

        function void search_nearest();
            int         k;
            int         len;
            int         filled;
            int         pos;
            int         j;
            int         d;
            int         diff;
            int         best_d[MAX_K];
            int         best_i[MAX_K];
            neighbour_t n;
            k      = (k_reg > MAX_K) ? MAX_K : k_reg;
            len    = active_len();
            filled = 0;
            if (k == 0 || ref_total == 0) begin
                n = '{index: '0, dist_sq: '0, err: 1'b1, last: 1'b1};
                pending = {pending, n};
                return;
            end
            for (int i = 0; i < ref_total; i++) begin
                d = 0;
                for (int e = 0; e < len; e++) begin
                    diff = int'(query_mem[e]) - int'(ref_mem[i*MAX_LEN + e]);
                    d += diff * diff;
                end
                if (d > DIST_MAX) d = DIST_MAX;
                pos = filled;
                while (pos > 0 && d < best_d[pos-1]) pos--;
                if (pos < k) begin
                    j = (filled < k) ? filled : k - 1;
                    while (j > pos) begin
                        best_d[j] = best_d[j-1];
                        best_i[j] = best_i[j-1];
                        j--;
                    end
                    best_d[pos] = d;
                    best_i[pos] = i;
                    if (filled < k) filled++;
                end
            end
            for (int i = 0; i < filled; i++) begin
                n.index   = best_i[i][IDX_W-1:0];
                n.dist_sq = best_d[i][DIST_W-1:0];
                n.err     = 1'b0;
                n.last    = (i + 1 == filled);
                pending = {pending, n};
            end
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [ELEM_W-1:0] val);
            int len;
            len = active_len();
            case (kind)
                KIND_REF: begin
                    if (ref_total < NUM_REFS) begin
                        if (load_pos < len) begin
                            ref_mem[ref_total*MAX_LEN + load_pos] = val;
                            load_pos++;
                        end
                        if (load_pos >= len) begin
                            load_pos = 0;
                            ref_total++;
                        end
                    end
                end
                KIND_QUERY: begin
                    if (query_pos < len) begin
                        query_mem[query_pos] = val;
                        query_pos++;
                    end
                    if (query_pos >= len) begin
                        query_pos = 0;
                        search_nearest();
                    end
                end
                KIND_CLEAR: begin
                    ref_total = 0;
                    load_pos  = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] dist_val,
                                   logic err, logic last);
            neighbour_t n;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d dist %0d err %0b last %0b",
                             idx, dist_val, err, last);
                return;
            end
            n = pending.pop_front();
            if (idx !== n.index || dist_val !== n.dist_sq || err !== n.err ||
                last !== n.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp index %0d dist %0d err %0b last %0b, %s",
                             n.index, n.dist_sq, n.err, n.last,
                             $sformatf("got %0d %0d %0b %0b", idx, dist_val, err, last));
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind = '0;
    logic [ELEM_W-1:0]    s_element_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_neighbour_index;
    logic [DIST_W-1:0]    m_distance_squared;
    logic                 m_error;
    logic                 m_last;

    knn_scoreboard sb = new();
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;
    bit            hold_seen = 1'b0;
    int            hold_left = 0;
    int            burst_left = 0;
    int            quiet_cycles = 0;
    int            requests_sent = 0;

    always #5 aclk = ~aclk;

    descriptor_knn_search u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_element_value    (s_element_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_neighbour_index  (m_neighbour_index),
        .m_distance_squared (m_distance_squared),
        .m_error            (m_error),
        .m_last             (m_last)
    );

    // result side: random stall bursts plus one long hold on request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_neighbour_index, m_distance_squared, m_error, m_last);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL descriptor_knn_search");
            $finish;
        end
    end

    task automatic send(logic [KIND_W-1:0] kind, logic [ELEM_W-1:0] val);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_element_value <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, val);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // one idle cycle after each write keeps the enable to one update per edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_DAT_W'(val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // values from a narrow range give many equal distances
    function automatic logic [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return ELEM_W'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: return ELEM_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_vector(logic [KIND_W-1:0] kind, int len);
        for (int e = 0; e < len; e++) send(kind, pick_value());
    endtask

    // new settings, then a fresh reference set so no stale element is read
    task automatic run_phase(int k, int len, int n_refs, int n_queries);
        int eff;
        wait_drained();
        write_reg(REG_NEIGHBOUR_COUNT, k);
        write_reg(REG_DESCRIPTOR_LENGTH, len);
        eff = sb.active_len();
        send(KIND_CLEAR, pick_value());
        for (int r = 0; r < n_refs; r++) begin
            send_vector(KIND_REF, eff);
            if ($urandom_range(0, 5) == 0) send_vector(KIND_QUERY, eff);
            if ($urandom_range(0, 15) == 0) send(KIND_UNKNOWN, pick_value());
        end
        for (int q = 0; q < n_queries; q++) send_vector(KIND_QUERY, eff);
        if ($urandom_range(0, 7) == 0) begin
            send(KIND_CLEAR, pick_value());
            send_vector(KIND_QUERY, eff);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty set, extremes, unknown kind, k of zero, clear
        write_reg(REG_DESCRIPTOR_LENGTH, 2);
        write_reg(REG_NEIGHBOUR_COUNT, 3);
        send(KIND_QUERY, 8'd7);
        send(KIND_QUERY, 8'd9);
        send(KIND_REF, 8'h00);
        send(KIND_REF, 8'hff);
        send(KIND_REF, 8'hff);
        send(KIND_REF, 8'h00);
        send(KIND_REF, 8'h00);
        send(KIND_REF, 8'h00);
        send(KIND_REF, 8'hff);
        send(KIND_REF, 8'hff);
        send(KIND_UNKNOWN, 8'haa);
        send(KIND_QUERY, 8'hff);
        send(KIND_QUERY, 8'hff);
        send(KIND_QUERY, 8'h80);
        send(KIND_QUERY, 8'h80);
        wait_drained();
        write_reg(REG_NEIGHBOUR_COUNT, 0);
        send(KIND_QUERY, 8'h00);
        send(KIND_QUERY, 8'h00);
        wait_drained();
        write_reg(REG_NEIGHBOUR_COUNT, 2);
        send(KIND_CLEAR, 8'h55);
        send(KIND_QUERY, 8'h01);
        send(KIND_QUERY, 8'h02);
        wait_drained();

        // long result stall while requests keep coming
        hold_req = ~hold_req;
        run_phase(16, 1, 6, 12);

        // corner settings: length zero, oversized count
        run_phase(31, 0, 20, 3);

        while (requests_sent < 100) begin
            if ($urandom_range(0, 9) == 0)
                run_phase($urandom_range(0, 31), $urandom_range(0, 255) > 200 ? 0 : 1,
                          $urandom_range(0, 12), $urandom_range(1, 3));
            else
                run_phase($urandom_range(0, 17), $urandom_range(1, 4),
                          $urandom_range(0, 6), $urandom_range(1, 2));
        end

        idle_on = 1'b0;
        run_phase(MAX_K, 4, 4, 2);
        run_phase(1, 3, 3, 1);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS descriptor_knn_search");
        end else begin
            $display("FAIL descriptor_knn_search");
        end
        $finish;
    end
endmodule
